/* rtl/core/text_screen_diff_ansi_encoder_core_macros.svh */
// Assertion macros for the screen differ and ANSI encoder.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef TEXT_SCREEN_DIFF_ANSI_ENCODER_CORE_MACROS_SVH
`define TEXT_SCREEN_DIFF_ANSI_ENCODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TSDE_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("tsde assertion failed");
`define TSDE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tsde assertion failed");
`else
`define TSDE_ASSERT(lbl, expr)
`define TSDE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/tsde_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsde_pkg
// Shared types, constants and the decimal digit helper of the ANSI encoder.
// ----------------------------------------------------------------------------
package tsde_pkg;

  localparam int unsigned MaxWidthDef  = 128;
  localparam int unsigned MaxHeightDef = 64;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_RESTART = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_BLANK_CH = 3'd2;
  localparam logic [2:0] REG_BLANK_FG = 3'd3;
  localparam logic [2:0] REG_BLANK_BG = 3'd4;

  localparam logic [7:0] ResetWidth  = 8'd80;
  localparam logic [6:0] ResetHeight = 7'd24;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // One screen cell.
  typedef struct packed {
    logic [7:0] bg;
    logic [7:0] fg;
    logic [7:0] ch;
  } cell_t;

  // Decimal form of an 8-bit value: digit count and the three digits.
  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][3:0] d;
  } dec_t;

  function automatic dec_t dec_fn(input logic [7:0] v);
    dec_t       res;
    logic [1:0] h;
    logic [6:0] r;
    logic [3:0] t;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = 7'(v - 8'(h) * 8'd100);
    t = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (r >= 7'(i * 10)) t = 4'(i);
    end
    res.d[2] = 4'(h);
    res.d[1] = t;
    res.d[0] = 4'(r - 7'(t) * 7'd10);
    res.n    = (v >= 8'd100) ? 2'd3 : ((v >= 8'd10) ? 2'd2 : 2'd1);
    return res;
  endfunction

endpackage

/* rtl/core/tsde_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsde_if
// Valid/ready channels of the encoder: input words, output words, config.
// ----------------------------------------------------------------------------
interface tsde_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] col;
  logic [7:0] row;
  logic [7:0] glyph;
  logic [7:0] fore_color;
  logic [7:0] back_color;
  modport source (output valid, op, col, row, glyph, fore_color, back_color, input ready);
  modport sink (input valid, op, col, row, glyph, fore_color, back_color, output ready);
endinterface

interface tsde_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] out_byte;
  logic       last;
  logic       frame_done;
  modport source (output valid, byte_valid, out_byte, last, frame_done, input ready);
  modport sink (input valid, byte_valid, out_byte, last, frame_done, output ready);
endinterface

interface tsde_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/tsde_cell_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsde_cell_ram
// Single-port-write, single-port-read screen store with registered read data.
// ----------------------------------------------------------------------------
module tsde_cell_ram #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  tsde_pkg::cell_t     wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output tsde_pkg::cell_t     rdata_o
);

  tsde_pkg::cell_t mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/text_screen_diff_ansi_encoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_screen_diff_ansi_encoder_core
// Two-screen character differ that turns changed cells into ANSI bytes.
// ----------------------------------------------------------------------------
// Sequence: after reset the block runs a clearing pass over both screen stores
// before it takes the first word. A clear word sweeps the current store and a
// restart word sweeps both stores, one cell a cycle. A flush step reads and
// compares the cell, then sends up to 37 output bytes, one per cycle while the
// output register is free, through a single byte sequencer; the output
// register lets the last byte wait while the next word is taken.
`include "text_screen_diff_ansi_encoder_core_macros.svh"

module text_screen_diff_ansi_encoder_core #(
  parameter int unsigned MAX_WIDTH  = tsde_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = tsde_pkg::MaxHeightDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  tsde_in_if.sink    in_i,
  tsde_out_if.source out_o,
  tsde_cfg_if.sink   cfg_i
);

  localparam int unsigned Cells = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_SET, ST_SWEEP, ST_RD, ST_CMP, ST_EMIT, ST_ACK
  } state_e;

  typedef enum logic [3:0] {
    PH_NONE, PH_CLS, PH_PHEAD, PH_PY, PH_PSEP, PH_PX, PH_PH,
    PH_FHEAD, PH_FD, PH_FM, PH_BHEAD, PH_BD, PH_BM, PH_CH
  } phase_e;

  state_e state_q;
  phase_e ph_q;
  logic [2:0] k_q;

  // Configuration registers.
  logic [7:0] cfg_w_q, cfg_ch_q, cfg_fg_q, cfg_bg_q;
  logic [6:0] cfg_h_q;

  // Applied geometry and scan state.
  logic [WW-1:0] act_w_q;
  logic [HW-1:0] act_h_q;
  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [AW-1:0] rb_q;
  logic          full_q, known_q, fd_q, emit_q, fneed_q, bneed_q;
  logic [7:0]    lfg_q, lbg_q, ex_q, ey_q;
  tsde_pkg::cell_t cell_q;

  // Latched word and sweep control.
  logic [7:0]    col_q, row_q;
  tsde_pkg::cell_t wcell_q;
  logic [AW-1:0] sw_q;
  logic          sw_both_q;
  tsde_pkg::cell_t fill_q;

  // Output register.
  logic       ov_q, obv_q, ol_q, ofd_q;
  logic [7:0] ob_q;

  // Store ports.
  logic            cur_we, shn_we;
  logic [AW-1:0]   cur_wa, shn_wa, scan_idx;
  tsde_pkg::cell_t cur_wd, shn_wd, cur_rd, shn_rd;

  tsde_cell_ram #(.Depth(Cells), .AddrW(AW)) u_cur (
    .clk_i, .we_i(cur_we), .waddr_i(cur_wa), .wdata_i(cur_wd),
    .raddr_i(scan_idx), .rdata_o(cur_rd)
  );

  tsde_cell_ram #(.Depth(Cells), .AddrW(AW)) u_shn (
    .clk_i, .we_i(shn_we), .waddr_i(shn_wa), .wdata_i(shn_wd),
    .raddr_i(scan_idx), .rdata_o(shn_rd)
  );

  // Handshakes.
  logic slot_free, in_acc;
  assign slot_free   = !ov_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid      = ov_q;
  assign out_o.byte_valid = obv_q;
  assign out_o.out_byte   = ob_q;
  assign out_o.last       = ol_q;
  assign out_o.frame_done = ofd_q;

  // Set address and bounds.
  logic [15:0] set_lin;
  logic        set_in;
  assign set_lin = 16'(row_q) * 16'(MAX_WIDTH) + 16'(col_q);
  assign set_in  = (col_q < 8'(act_w_q)) && (row_q < 8'(act_h_q));

  assign scan_idx = rb_q + AW'(x_q);

  // Compare stage: decide what the scanned cell needs.
  tsde_pkg::cell_t blank_c;
  logic p0, known_c, emit_c, fneed_c, bneed_c, lastcell;
  logic [7:0] lfg_c, lbg_c;
  assign blank_c  = '{bg: cfg_bg_q, fg: cfg_fg_q, ch: cfg_ch_q};
  assign p0       = (x_q == '0) && (y_q == '0);
  assign known_c  = p0 ? 1'b0 : known_q;
  assign lfg_c    = p0 ? 8'd0 : lfg_q;
  assign lbg_c    = p0 ? 8'd0 : lbg_q;
  assign emit_c   = full_q ? (cur_rd != blank_c) : (cur_rd != shn_rd);
  assign fneed_c  = !known_c || (cur_rd.fg != lfg_c);
  assign bneed_c  = !known_c || (cur_rd.bg != lbg_c);
  assign lastcell = (WW'(x_q) == act_w_q - WW'(1)) && (HW'(y_q) == act_h_q - HW'(1));

  // Store write control.
  always_comb begin
    cur_we = 1'b0;
    cur_wa = sw_q;
    cur_wd = fill_q;
    shn_we = 1'b0;
    shn_wa = sw_q;
    shn_wd = fill_q;
    case (state_q)
      ST_INIT, ST_SWEEP: begin
        cur_we = 1'b1;
        shn_we = (state_q == ST_INIT) || sw_both_q;
      end
      ST_SET: begin
        cur_we = set_in;
        cur_wa = set_lin[AW-1:0];
        cur_wd = wcell_q;
      end
      ST_CMP: begin
        shn_we = 1'b1;
        shn_wa = scan_idx;
        shn_wd = cur_rd;
      end
      default: begin
      end
    endcase
  end

  // Byte sequencer: byte of the current phase and what follows it.
  logic [7:0]     dval;
  tsde_pkg::dec_t dec_c;
  logic [7:0]     byte_c;
  logic [2:0]     len_c;
  phase_e         nxt_c;
  logic [1:0]     dpos;
  assign dec_c = tsde_pkg::dec_fn(dval);
  assign dpos  = dec_c.n - 2'd1 - k_q[1:0];

  always_comb begin
    dval   = 8'd0;
    byte_c = 8'd0;
    len_c  = 3'd1;
    nxt_c  = PH_NONE;
    case (ph_q)
      PH_CLS: begin
        len_c = 3'd4;
        case (k_q)
          3'd0: byte_c = tsde_pkg::CH_ESC;
          3'd1: byte_c = tsde_pkg::CH_LBR;
          3'd2: byte_c = 8'h32;
          default: byte_c = 8'h4A;
        endcase
        nxt_c = emit_q ? PH_PHEAD : PH_NONE;
      end
      PH_PHEAD: begin
        len_c  = 3'd2;
        byte_c = (k_q == 3'd0) ? tsde_pkg::CH_ESC : tsde_pkg::CH_LBR;
        nxt_c  = PH_PY;
      end
      PH_PY, PH_PX, PH_FD, PH_BD: begin
        case (ph_q)
          PH_PY:   begin dval = ey_q;      nxt_c = PH_PSEP; end
          PH_PX:   begin dval = ex_q;      nxt_c = PH_PH;   end
          PH_FD:   begin dval = cell_q.fg; nxt_c = PH_FM;   end
          default: begin dval = cell_q.bg; nxt_c = PH_BM;   end
        endcase
        len_c  = {1'b0, dec_c.n};
        byte_c = tsde_pkg::CH_ZERO | {4'd0, dec_c.d[dpos]};
      end
      PH_PSEP: begin
        byte_c = tsde_pkg::CH_SEMI;
        nxt_c  = PH_PX;
      end
      PH_PH: begin
        byte_c = 8'h48;
        nxt_c  = fneed_q ? PH_FHEAD : (bneed_q ? PH_BHEAD : PH_CH);
      end
      PH_FHEAD, PH_BHEAD: begin
        len_c = 3'd7;
        case (k_q)
          3'd0: byte_c = tsde_pkg::CH_ESC;
          3'd1: byte_c = tsde_pkg::CH_LBR;
          3'd2: byte_c = (ph_q == PH_FHEAD) ? 8'h33 : 8'h34;
          3'd3: byte_c = 8'h38;
          3'd5: byte_c = 8'h35;
          default: byte_c = tsde_pkg::CH_SEMI;
        endcase
        nxt_c = (ph_q == PH_FHEAD) ? PH_FD : PH_BD;
      end
      PH_FM: begin
        byte_c = 8'h6D;
        nxt_c  = bneed_q ? PH_BHEAD : PH_CH;
      end
      PH_BM: begin
        byte_c = 8'h6D;
        nxt_c  = PH_CH;
      end
      PH_CH: begin
        byte_c = cell_q.ch;
      end
      default: begin
      end
    endcase
  end

  logic ph_end, seq_last;
  assign ph_end   = (k_q == len_c - 3'd1);
  assign seq_last = ph_end && (nxt_c == PH_NONE);

  // Sequencer, scan state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      ph_q      <= PH_NONE;
      k_q       <= '0;
      cfg_w_q   <= tsde_pkg::ResetWidth;
      cfg_h_q   <= tsde_pkg::ResetHeight;
      cfg_ch_q  <= '0;
      cfg_fg_q  <= '0;
      cfg_bg_q  <= '0;
      act_w_q   <= WW'(tsde_pkg::ResetWidth > 8'(MAX_WIDTH) ? 8'(MAX_WIDTH)
                                                            : tsde_pkg::ResetWidth);
      act_h_q   <= HW'(8'(tsde_pkg::ResetHeight) > 8'(MAX_HEIGHT) ? 8'(MAX_HEIGHT)
                                                                  : 8'(tsde_pkg::ResetHeight));
      x_q       <= '0;
      y_q       <= '0;
      rb_q      <= '0;
      full_q    <= 1'b1;
      known_q   <= 1'b0;
      lfg_q     <= '0;
      lbg_q     <= '0;
      fd_q      <= 1'b0;
      emit_q    <= 1'b0;
      fneed_q   <= 1'b0;
      bneed_q   <= 1'b0;
      sw_q      <= '0;
      sw_both_q <= 1'b1;
      fill_q    <= '0;
      ov_q      <= 1'b0;
      obv_q     <= 1'b0;
      ob_q      <= '0;
      ol_q      <= 1'b0;
      ofd_q     <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_i.valid) begin
        case (cfg_i.index)
          tsde_pkg::REG_WIDTH:    cfg_w_q  <= cfg_i.data;
          tsde_pkg::REG_HEIGHT:   cfg_h_q  <= cfg_i.data[6:0];
          tsde_pkg::REG_BLANK_CH: cfg_ch_q <= cfg_i.data;
          tsde_pkg::REG_BLANK_FG: cfg_fg_q <= cfg_i.data;
          tsde_pkg::REG_BLANK_BG: cfg_bg_q <= cfg_i.data;
          default: begin
          end
        endcase
      end

      if (ov_q && out_o.ready) begin
        ov_q <= 1'b0;
      end

      case (state_q)
        ST_INIT, ST_SWEEP: begin
          sw_q <= sw_q + AW'(1);
          if (sw_q == AW'(Cells - 1)) begin
            sw_q    <= '0;
            state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_ACK;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            col_q   <= in_i.col;
            row_q   <= in_i.row;
            wcell_q <= '{bg: in_i.back_color, fg: in_i.fore_color, ch: in_i.glyph};
            fd_q    <= 1'b0;
            fill_q  <= blank_c;
            case (tsde_pkg::op_e'(in_i.op))
              tsde_pkg::OP_SET: state_q <= ST_SET;
              tsde_pkg::OP_CLEAR: begin
                sw_both_q <= 1'b0;
                state_q   <= ST_SWEEP;
              end
              tsde_pkg::OP_RESTART: begin
                sw_both_q <= 1'b1;
                act_w_q   <= (cfg_w_q == 8'd0) ? WW'(1) :
                             ((cfg_w_q > 8'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_w_q));
                act_h_q   <= (cfg_h_q == 7'd0) ? HW'(1) :
                             (({1'b0, cfg_h_q} > 8'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                                                                 : HW'(cfg_h_q));
                x_q       <= '0;
                y_q       <= '0;
                rb_q      <= '0;
                full_q    <= 1'b1;
                known_q   <= 1'b0;
                lfg_q     <= '0;
                lbg_q     <= '0;
                state_q   <= ST_SWEEP;
              end
              default: state_q <= ST_RD;
            endcase
          end
        end
        ST_SET: begin
          state_q <= ST_ACK;
        end
        ST_RD: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          cell_q  <= cur_rd;
          emit_q  <= emit_c;
          fneed_q <= fneed_c;
          bneed_q <= bneed_c;
          ex_q    <= 8'(x_q) + 8'd1;
          ey_q    <= 8'(y_q) + 8'd1;
          fd_q    <= lastcell;
          if (emit_c) begin
            known_q <= 1'b1;
            lfg_q   <= cur_rd.fg;
            lbg_q   <= cur_rd.bg;
          end else if (p0) begin
            known_q <= 1'b0;
            lfg_q   <= '0;
            lbg_q   <= '0;
          end
          // Advance the raster position.
          if (lastcell) begin
            x_q    <= '0;
            y_q    <= '0;
            rb_q   <= '0;
            full_q <= 1'b0;
          end else if (WW'(x_q) == act_w_q - WW'(1)) begin
            x_q  <= '0;
            y_q  <= y_q + YW'(1);
            rb_q <= rb_q + AW'(MAX_WIDTH);
          end else begin
            x_q <= x_q + XW'(1);
          end
          k_q <= '0;
          if (p0 && full_q) begin
            ph_q    <= PH_CLS;
            state_q <= ST_EMIT;
          end else if (emit_c) begin
            ph_q    <= PH_PHEAD;
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_ACK;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            ov_q  <= 1'b1;
            obv_q <= 1'b1;
            ob_q  <= byte_c;
            ol_q  <= seq_last;
            ofd_q <= seq_last && fd_q;
            if (ph_end) begin
              k_q  <= '0;
              ph_q <= nxt_c;
            end else begin
              k_q <= k_q + 3'd1;
            end
            if (seq_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_ACK: begin
          if (slot_free) begin
            ov_q    <= 1'b1;
            obv_q   <= 1'b0;
            ob_q    <= '0;
            ol_q    <= 1'b1;
            ofd_q   <= fd_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Checks on the sequencer and scan state.
  `TSDE_ASSERT(a_ack_is_last, !(out_o.valid && !out_o.byte_valid) || out_o.last)
  `TSDE_ASSERT(a_frame_done_last, !(out_o.valid && out_o.frame_done) || out_o.last)
  `TSDE_ASSERT(a_scan_in_screen, (WW'(x_q) < act_w_q) && (HW'(y_q) < act_h_q))
  `TSDE_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready)

endmodule

/* sim/tb_text_screen_diff_ansi_encoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_screen_diff_ansi_encoder_core
// Self-checking bench for the screen differ and ANSI byte encoder.
// A clocked driver offers input words from a queue of pending words, and a
// clocked monitor takes output words under random back-pressure. Each
// accepted input word is run through a local copy of both screens, which
// yields the bytes the block must send. Every output word is compared with
// the oldest of them. Several screen sizes and blank cells are exercised,
// including both saturation limits.
// ----------------------------------------------------------------------------
module tb_text_screen_diff_ansi_encoder_core;

  localparam int unsigned Cells     = tsde_pkg::MaxWidthDef * tsde_pkg::MaxHeightDef;
  localparam int unsigned CycleCap  = 1_500_000;
  localparam int unsigned HoldLen   = 400;
  localparam logic [7:0]  ChTwo     = 8'h32;
  localparam logic [7:0]  ChThree   = 8'h33;
  localparam logic [7:0]  ChFour    = 8'h34;
  localparam logic [7:0]  ChFive    = 8'h35;
  localparam logic [7:0]  ChEight   = 8'h38;
  localparam logic [7:0]  ChUpperJ  = 8'h4A;
  localparam logic [7:0]  ChUpperH  = 8'h48;
  localparam logic [7:0]  ChLowerM  = 8'h6D;

  typedef struct packed {
    tsde_pkg::op_e op;
    logic [7:0]    col;
    logic [7:0]    row;
    logic [7:0]    glyph;
    logic [7:0]    fg;
    logic [7:0]    bg;
  } word_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       last;
    logic       frame_done;
  } ansi_t;

  typedef struct packed {
    logic [2:0] index;
    logic [7:0] data;
  } reg_wr_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  tsde_in_if  in_i ();
  tsde_out_if out_o ();
  tsde_cfg_if cfg_i ();

  text_screen_diff_ansi_encoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i)
  );

  // Local screen copies and encoder state.
  tsde_pkg::cell_t cur_scr   [Cells];
  tsde_pkg::cell_t shown_scr [Cells];
  logic       redraw_all;
  int unsigned scan_pos;
  logic       color_seen;
  logic [7:0] prev_fg;
  logic [7:0] prev_bg;
  logic [7:0] reg_w, reg_blank_ch, reg_blank_fg, reg_blank_bg;
  logic [6:0] reg_h;
  int unsigned cols_used, rows_used;

  word_t   pending_q [$];
  reg_wr_t reg_wr_q  [$];
  ansi_t   ansi_expect_q [$];
  logic [7:0] byte_buf [$];

  word_t  drv_word;
  int     drv_gap;
  int     mon_gap;
  int     hold_cnt;
  bit     hold_req;
  bit     hold_done = 1'b0;
  bit     quiet;
  int     fails;
  int unsigned cycles;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic tsde_pkg::cell_t blank_now();
    return '{bg: reg_blank_bg, fg: reg_blank_fg, ch: reg_blank_ch};
  endfunction

  function automatic void fill_screen(bit both);
    tsde_pkg::cell_t b;
    b = blank_now();
    for (int i = 0; i < Cells; i++) begin
      cur_scr[i] = b;
      if (both) shown_scr[i] = b;
    end
  endfunction

  function automatic void put_decimal(int unsigned v);
    if (v >= 100) byte_buf.push_back(8'(tsde_pkg::CH_ZERO + v / 100));
    if (v >= 10) byte_buf.push_back(8'(tsde_pkg::CH_ZERO + (v / 10) % 10));
    byte_buf.push_back(8'(tsde_pkg::CH_ZERO + v % 10));
  endfunction

  function automatic void put_color(logic [7:0] sel, logic [7:0] v);
    byte_buf.push_back(tsde_pkg::CH_ESC);
    byte_buf.push_back(tsde_pkg::CH_LBR);
    byte_buf.push_back(sel);
    byte_buf.push_back(ChEight);
    byte_buf.push_back(tsde_pkg::CH_SEMI);
    byte_buf.push_back(ChFive);
    byte_buf.push_back(tsde_pkg::CH_SEMI);
    put_decimal(v);
    byte_buf.push_back(ChLowerM);
  endfunction

  // Works out the output words caused by one accepted input word.
  function automatic void encode_word(word_t w);
    int unsigned     total, p, x, y, idx;
    tsde_pkg::cell_t c;
    bit              emit, fd;
    ansi_t           r;
    fd = 1'b0;
    byte_buf.delete();
    case (w.op)
      tsde_pkg::OP_SET: begin
        if (w.col < cols_used && w.row < rows_used)
          cur_scr[w.row * tsde_pkg::MaxWidthDef + w.col] = '{bg: w.bg, fg: w.fg, ch: w.glyph};
      end
      tsde_pkg::OP_CLEAR: fill_screen(1'b0);
      tsde_pkg::OP_RESTART: begin
        cols_used = (reg_w < 1) ? 1 :
                    ((reg_w > tsde_pkg::MaxWidthDef) ? tsde_pkg::MaxWidthDef : reg_w);
        rows_used = (reg_h < 1) ? 1 :
                    ((reg_h > tsde_pkg::MaxHeightDef) ? tsde_pkg::MaxHeightDef : reg_h);
        fill_screen(1'b1);
        redraw_all = 1'b1;
        scan_pos   = 0;
        color_seen = 1'b0;
        prev_fg    = '0;
        prev_bg    = '0;
      end
      default: begin
        total = cols_used * rows_used;
        p = scan_pos;
        if (p >= total) p = 0;
        if (p == 0) begin
          color_seen = 1'b0;
          prev_fg    = '0;
          prev_bg    = '0;
          if (redraw_all) begin
            byte_buf.push_back(tsde_pkg::CH_ESC);
            byte_buf.push_back(tsde_pkg::CH_LBR);
            byte_buf.push_back(ChTwo);
            byte_buf.push_back(ChUpperJ);
          end
        end
        x = p % cols_used;
        y = p / cols_used;
        idx = y * tsde_pkg::MaxWidthDef + x;
        if (idx >= Cells) idx = 0;
        c = cur_scr[idx];
        emit = redraw_all ? (c != blank_now()) : (c != shown_scr[idx]);
        if (emit) begin
          byte_buf.push_back(tsde_pkg::CH_ESC);
          byte_buf.push_back(tsde_pkg::CH_LBR);
          put_decimal(y + 1);
          byte_buf.push_back(tsde_pkg::CH_SEMI);
          put_decimal(x + 1);
          byte_buf.push_back(ChUpperH);
          if (!color_seen || c.fg != prev_fg) put_color(ChThree, c.fg);
          if (!color_seen || c.bg != prev_bg) put_color(ChFour, c.bg);
          color_seen = 1'b1;
          prev_fg    = c.fg;
          prev_bg    = c.bg;
          byte_buf.push_back(c.ch);
        end
        shown_scr[idx] = c;
        p++;
        if (p >= total) begin
          scan_pos   = 0;
          redraw_all = 1'b0;
          fd         = 1'b1;
        end else begin
          scan_pos = p;
        end
      end
    endcase
    if (byte_buf.size() == 0) begin
      r = '{byte_valid: 1'b0, out_byte: 8'd0, last: 1'b1, frame_done: fd};
      ansi_expect_q.push_back(r);
    end else begin
      foreach (byte_buf[k]) begin
        r.byte_valid = 1'b1;
        r.out_byte   = byte_buf[k];
        r.last       = (k == byte_buf.size() - 1);
        r.frame_done = r.last && fd;
        ansi_expect_q.push_back(r);
      end
    end
  endfunction

  function automatic void apply_reg(reg_wr_t wr);
    case (wr.index)
      tsde_pkg::REG_WIDTH:    reg_w = wr.data;
      tsde_pkg::REG_HEIGHT:   reg_h = wr.data[6:0];
      tsde_pkg::REG_BLANK_CH: reg_blank_ch = wr.data;
      tsde_pkg::REG_BLANK_FG: reg_blank_fg = wr.data;
      tsde_pkg::REG_BLANK_BG: reg_blank_bg = wr.data;
      default: ;
    endcase
  endfunction

  // Input word driver, fed from the pending queue.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_i.valid <= 1'b0;
      drv_gap    = 0;
    end else begin
      if (in_i.valid && in_i.ready) encode_word(drv_word);
      if (!in_i.valid || in_i.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_i.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          drv_gap = $urandom_range(1, 6) - 1;
          in_i.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          drv_word = pending_q.pop_front();
          in_i.valid      <= 1'b1;
          in_i.op         <= drv_word.op;
          in_i.col        <= drv_word.col;
          in_i.row        <= drv_word.row;
          in_i.glyph      <= drv_word.glyph;
          in_i.fore_color <= drv_word.fg;
          in_i.back_color <= drv_word.bg;
        end else begin
          in_i.valid <= 1'b0;
        end
      end
    end
  end

  // Register write driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_i.valid <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) apply_reg('{index: cfg_i.index, data: cfg_i.data});
      if (!cfg_i.valid || cfg_i.ready) begin
        if (reg_wr_q.size() > 0) begin
          reg_wr_t wr;
          wr = reg_wr_q.pop_front();
          cfg_i.valid <= 1'b1;
          cfg_i.index <= wr.index;
          cfg_i.data  <= wr.data;
        end else begin
          cfg_i.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted in its own process.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt = 0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt  = HoldLen;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
    end
  end

  // Output word monitor with random stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
      mon_gap  = 0;
    end else begin
      if (out_o.valid && out_o.ready) begin
        if (ansi_expect_q.size() == 0) begin
          $error("unexpected output word: byte %02h", out_o.out_byte);
          fails++;
        end else begin
          ansi_t e;
          e = ansi_expect_q.pop_front();
          if (out_o.byte_valid !== e.byte_valid) begin
            $error("byte_valid: expected %0b actual %0b", e.byte_valid, out_o.byte_valid);
            fails++;
          end
          if (out_o.out_byte !== e.out_byte) begin
            $error("out_byte: expected %02h actual %02h", e.out_byte, out_o.out_byte);
            fails++;
          end
          if (out_o.last !== e.last) begin
            $error("last: expected %0b actual %0b", e.last, out_o.last);
            fails++;
          end
          if (out_o.frame_done !== e.frame_done) begin
            $error("frame_done: expected %0b actual %0b", e.frame_done, out_o.frame_done);
            fails++;
          end
        end
      end
      if (hold_cnt > 0) begin
        out_o.ready <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap--;
        out_o.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        mon_gap = $urandom_range(1, 6) - 1;
        out_o.ready <= 1'b0;
      end else begin
        out_o.ready <= 1'b1;
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_word(tsde_pkg::op_e op, int col, int row, int g, int f, int b);
    pending_q.push_back('{op: op, col: 8'(col), row: 8'(row), glyph: 8'(g), fg: 8'(f),
                          bg: 8'(b)});
  endtask

  task automatic push_reg(logic [2:0] idx, int v);
    reg_wr_q.push_back('{index: idx, data: 8'(v)});
  endtask

  // Waits until every word is through and the block has gone quiet.
  task automatic settle();
    while (pending_q.size() > 0 || in_i.valid || reg_wr_q.size() > 0 || cfg_i.valid ||
           ansi_expect_q.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_screen(int w, int h, int bc, int bf, int bb);
    push_reg(tsde_pkg::REG_WIDTH, w);
    push_reg(tsde_pkg::REG_HEIGHT, h);
    push_reg(tsde_pkg::REG_BLANK_CH, bc);
    push_reg(tsde_pkg::REG_BLANK_FG, bf);
    push_reg(tsde_pkg::REG_BLANK_BG, bb);
    settle();
    push_word(tsde_pkg::OP_RESTART, 0, 0, 0, 0, 0);
    settle();
  endtask

  // Mostly sets inside the screen and flush steps, with rare clears and restarts.
  task automatic random_words(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 42) begin
        if ($urandom_range(0, 5) == 0)
          push_word(tsde_pkg::OP_SET, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        else
          push_word(tsde_pkg::OP_SET, $urandom_range(0, cols_used - 1),
                    $urandom_range(0, rows_used - 1),
                    $urandom_range(0, 255), $urandom_range(0, 3) * 85,
                    $urandom_range(0, 255));
      end else if (k < 97) begin
        push_word(tsde_pkg::OP_FLUSH, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (k < 99) begin
        push_word(tsde_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
      end else begin
        push_word(tsde_pkg::OP_RESTART, 0, 0, 0, 0, 0);
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin
    in_i.valid = 1'b0;
    in_i.op = tsde_pkg::OP_SET;
    in_i.col = '0;
    in_i.row = '0;
    in_i.glyph = '0;
    in_i.fore_color = '0;
    in_i.back_color = '0;
    out_o.ready = 1'b0;
    cfg_i.valid = 1'b0;
    cfg_i.index = '0;
    cfg_i.data = '0;
    fails = 0;
    cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    reg_w = tsde_pkg::ResetWidth;
    reg_h = tsde_pkg::ResetHeight;
    reg_blank_ch = '0;
    reg_blank_fg = '0;
    reg_blank_bg = '0;
    cols_used = tsde_pkg::ResetWidth;
    rows_used = tsde_pkg::ResetHeight;
    redraw_all = 1'b1;
    scan_pos = 0;
    color_seen = 1'b0;
    prev_fg = '0;
    prev_bg = '0;
    for (int i = 0; i < Cells; i++) begin
      cur_scr[i] = '0;
      shown_scr[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset size: corners, cells just outside, and decimal digit boundaries.
    push_word(tsde_pkg::OP_SET, 0, 0, 255, 255, 0);
    push_word(tsde_pkg::OP_SET, 1, 0, 0, 255, 255);
    push_word(tsde_pkg::OP_SET, 79, 23, 65, 9, 10);
    push_word(tsde_pkg::OP_SET, 80, 0, 1, 2, 3);
    push_word(tsde_pkg::OP_SET, 0, 24, 1, 2, 3);
    push_word(tsde_pkg::OP_SET, 255, 255, 1, 2, 3);
    push_word(tsde_pkg::OP_FLUSH, 0, 0, 0, 0, 0);
    push_word(tsde_pkg::OP_FLUSH, 0, 0, 0, 0, 0);
    push_word(tsde_pkg::OP_FLUSH, 0, 0, 0, 0, 0);
    settle();

    // Tiny screen: full frame, then diffs, a clear, a restart mid frame.
    set_screen(3, 2, 32, 7, 0);
    push_word(tsde_pkg::OP_SET, 2, 1, 66, 99, 100);
    push_word(tsde_pkg::OP_SET, 1, 0, 32, 7, 0);
    push_word(tsde_pkg::OP_SET, 0, 1, 67, 99, 100);
    for (int i = 0; i < 7; i++) push_word(tsde_pkg::OP_FLUSH, 0, 0, 0, 0, 0);
    push_word(tsde_pkg::OP_SET, 2, 1, 68, 99, 101);
    for (int i = 0; i < 6; i++) push_word(tsde_pkg::OP_FLUSH, 0, 0, 0, 0, 0);
    push_word(tsde_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    push_word(tsde_pkg::OP_FLUSH, 0, 0, 0, 0, 0);
    push_word(tsde_pkg::OP_RESTART, 0, 0, 0, 0, 0);
    push_word(tsde_pkg::OP_FLUSH, 0, 0, 0, 0, 0);
    settle();

    // Blank char changed without a restart: the redraw skip uses the new one.
    push_reg(tsde_pkg::REG_BLANK_CH, 46);
    settle();
    for (int i = 0; i < 3; i++) push_word(tsde_pkg::OP_FLUSH, 0, 0, 0, 0, 0);
    settle();

    // Saturation at the low end: one cell.
    set_screen(0, 0, 255, 255, 255);
    random_words(14);
    settle();

    // Saturation at the high end, with the long receiver hold-off while words wait.
    set_screen(255, 127, 0, 0, 0);
    random_words(16);
    hold_req = 1'b1;
    settle();

    set_screen(4, 3, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    random_words(20);
    settle();

    // Last part without idling on either side.
    quiet = 1'b1;
    set_screen(2, 5, 0, 128, 1);
    random_words(20);
    settle();
    repeat (100) @(posedge clk_i);

    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/tsde_pkg.sv
rtl/core/tsde_if.sv
rtl/core/tsde_cell_ram.sv
rtl/core/text_screen_diff_ansi_encoder_core.sv
sim/tb_text_screen_diff_ansi_encoder_core.sv
